### hw/rtl/ghs_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the global health supervision state machine
// no dependencies; imported by every module of the block

package ghs_pkg;

    // global status codes
    typedef enum logic [2:0] {
        ST_DEACT   = 3'd0,
        ST_OK      = 3'd1,
        ST_FAILED  = 3'd2,
        ST_EXPIRED = 3'd3,
        ST_STOPPED = 3'd4
    } t_status;

    // request command codes, code 3 is unused
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_MODE   = 2'd1,
        CMD_REPORT = 2'd2
    } t_cmd;

    // local lane status codes
    localparam logic [1:0] LS_DEACT   = 2'd0;
    localparam logic [1:0] LS_FAILED  = 2'd2;
    localparam logic [1:0] LS_EXPIRED = 2'd3;

    // lanes carried by the request
    localparam int LANE_W    = 2;
    localparam int LANES_W   = 16;
    localparam int LANES_MAX = LANES_W / LANE_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER   = 1'd1;
    localparam int CFG_DATA_W = 8;

    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic active;
        logic failed;
        logic expired;
    } t_lane_flags;

    typedef struct packed {
        logic [COUNT_W-1:0] tolerance;
        logic               handler;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         cluster;
        logic [7:0]         process;
        logic [1:0]         cause_type;
        logic               notify;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_result;

endpackage

### hw/rtl/ghs_lane_reduce.sv
`timescale 1ns / 1ps
// or-reduction of the packed local supervision lanes into three flags
// depends on ghs_pkg

module ghs_lane_reduce #(
    parameter int LOCAL_COUNT = 8
) (
    input  logic [ghs_pkg::LANES_W-1:0] i_lanes,
    output ghs_pkg::t_lane_flags        o_flags
);
    import ghs_pkg::*;

    // lanes past the request width read as deactivated
    localparam int USED = (LOCAL_COUNT < LANES_MAX) ? LOCAL_COUNT : LANES_MAX;

    logic [USED-1:0] w_act;
    logic [USED-1:0] w_fail;
    logic [USED-1:0] w_exp;

    for (genvar g = 0; g < USED; g++) begin : g_lane
        assign w_act[g]  = (i_lanes[g*LANE_W +: LANE_W] != LS_DEACT);
        assign w_fail[g] = (i_lanes[g*LANE_W +: LANE_W] == LS_FAILED);
        assign w_exp[g]  = (i_lanes[g*LANE_W +: LANE_W] == LS_EXPIRED);
    end

    assign o_flags.active  = |w_act;
    assign o_flags.failed  = |w_fail;
    assign o_flags.expired = |w_exp;

endmodule

### hw/rtl/ghs_fsm_core.sv
`timescale 1ns / 1ps
// supervision state, expired counter and latched expiry cause
// depends on ghs_pkg; fed by ghs_lane_reduce flags

module ghs_fsm_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [1:0]           i_cmd,
    input  ghs_pkg::t_lane_flags i_flags,
    input  logic [1:0]           i_report_status,
    input  logic [1:0]           i_report_type,
    input  logic [7:0]           i_report_process,
    input  logic [1:0]           i_report_cluster,
    input  ghs_pkg::t_cfg        i_cfg,
    output ghs_pkg::t_result     o_next
);
    import ghs_pkg::*;

    t_status            r_status, n_status;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_tick_en, n_tick_en;
    logic [1:0]         r_type, n_type;
    logic [7:0]         r_process, n_process;
    logic [1:0]         r_cluster, n_cluster;
    logic               n_notify;
    logic [COUNT_W-1:0] w_count_inc;

    // saturating increment
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);

    always_comb begin
        n_status  = r_status;
        n_count   = r_count;
        n_tick_en = r_tick_en;
        n_type    = r_type;
        n_process = r_process;
        n_cluster = r_cluster;
        n_notify  = 1'b0;
        case (i_cmd)
            CMD_TICK: begin
                if (r_tick_en) begin
                    if (!i_flags.active) begin
                        n_status = ST_DEACT;
                        n_count  = '0;
                    end else begin
                        case (r_status) inside
                            ST_OK, ST_FAILED: begin
                                if (!i_flags.expired && !i_flags.failed) begin
                                    n_status = ST_OK;
                                end else if (!i_flags.expired) begin
                                    n_status = ST_FAILED;
                                end else if (i_cfg.tolerance != '0) begin
                                    n_status = ST_EXPIRED;
                                    n_count  = w_count_inc;
                                end else begin
                                    n_status = ST_STOPPED;
                                end
                            end
                            ST_EXPIRED: begin
                                if (i_flags.expired && (r_count < i_cfg.tolerance)) begin
                                    n_count = w_count_inc;
                                end else if (i_flags.expired && (r_count == i_cfg.tolerance)) begin
                                    n_status = ST_STOPPED;
                                end
                            end
                            default: ;
                        endcase
                    end
                    n_notify = (n_status == ST_STOPPED) && i_cfg.handler;
                end
            end
            CMD_MODE: begin
                if (!i_flags.active) begin
                    n_tick_en = 1'b0;
                    n_status  = ST_DEACT;
                    n_count   = '0;
                end else begin
                    case (r_status)
                        ST_DEACT: begin
                            n_status  = ST_OK;
                            n_tick_en = 1'b1;
                        end
                        ST_FAILED: begin
                            if (!i_flags.failed) begin
                                n_status = ST_OK;
                                n_count  = '0;
                            end
                        end
                        ST_EXPIRED: begin
                            if (!i_flags.expired) begin
                                n_status = ST_OK;
                                n_count  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_REPORT: begin
                if (i_report_status == LS_EXPIRED) begin
                    n_type    = i_report_type;
                    n_process = i_report_process;
                    n_cluster = i_report_cluster;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= ST_DEACT;
            r_count   <= '0;
            r_tick_en <= 1'b1;
            r_type    <= '0;
            r_process <= '0;
            r_cluster <= '0;
        end else if (i_fire) begin
            r_status  <= n_status;
            r_count   <= n_count;
            r_tick_en <= n_tick_en;
            r_type    <= n_type;
            r_process <= n_process;
            r_cluster <= n_cluster;
        end
    end

    assign o_next.status     = n_status;
    assign o_next.count      = n_count;
    assign o_next.notify     = n_notify;
    assign o_next.cause_type = n_type;
    assign o_next.process    = n_process;
    assign o_next.cluster    = n_cluster;

endmodule

### hw/rtl/global_health_supervision_fsm_unit.sv
`timescale 1ns / 1ps
// top level of the global health supervision state machine
// depends on ghs_pkg, ghs_lane_reduce and ghs_fsm_core
//
// channel   | direction | handshake                      | contents
// ----------+-----------+--------------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | one request: command + fields
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | one result per request
// cfg       | in        | i_cfg_valid / o_cfg_ready      | register index + write data
//
// the accepted request sits in the input register; lane reduction and the state update
// then land in the result register when it is free to take them
// one request per cycle is sustained while m_axis is not stalled; the state update is a
// single short path
// reset clears state to deactivated, counter 0, tick timer running, cause 0
// a stalled m_axis holds the result register; the input register still takes
// one request and holds it until the result register frees

module global_health_supervision_fsm_unit #(
    parameter int LOCAL_COUNT = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // local_statuses[15:0], report_status[17:16], report_type[19:18],
    // report_process[27:20], report_cluster[29:28], zero pad[31:30]
    input  logic [ghs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [ghs_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // global_status[2:0], expired_cycles[10:3], notify[11], cause_type[13:12],
    // cause_process[21:14], cause_cluster[23:22]
    output logic [ghs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ghs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ghs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ghs_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic               r_in_valid;
    logic [1:0]         r_in_cmd;
    logic [LANES_W-1:0] r_in_lanes;
    logic [1:0]         r_in_rstatus;
    logic [1:0]         r_in_rtype;
    logic [7:0]         r_in_rprocess;
    logic [1:0]         r_in_rcluster;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic        w_out_free;
    logic        w_advance;
    logic        w_in_take;
    t_lane_flags w_flags;
    t_result     w_next;

    // result register can take a new value when empty or being drained
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance <= '0;
            r_cfg.handler   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOLERANCE: r_cfg.tolerance <= i_cfg_data[COUNT_W-1:0];
                CFG_HANDLER:   r_cfg.handler   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register, valid bit reset only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cmd      <= s_axis_tuser;
            r_in_lanes    <= s_axis_tdata[15:0];
            r_in_rstatus  <= s_axis_tdata[17:16];
            r_in_rtype    <= s_axis_tdata[19:18];
            r_in_rprocess <= s_axis_tdata[27:20];
            r_in_rcluster <= s_axis_tdata[29:28];
        end
    end

    ghs_lane_reduce #(
        .LOCAL_COUNT (LOCAL_COUNT)
    ) u_reduce (
        .i_lanes (r_in_lanes),
        .o_flags (w_flags)
    );

    ghs_fsm_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_advance),
        .i_cmd            (r_in_cmd),
        .i_flags          (w_flags),
        .i_report_status  (r_in_rstatus),
        .i_report_type    (r_in_rtype),
        .i_report_process (r_in_rprocess),
        .i_report_cluster (r_in_rcluster),
        .i_cfg            (r_cfg),
        .o_next           (w_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    // notify only ever reports a stopped machine
    a_notify_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.notify) |-> (r_out.status == ST_STOPPED))
        else $error("notify raised without stopped status");

    // a deactivated result always carries a cleared counter
    a_deact_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_DEACT)) |-> (r_out.count == '0))
        else $error("deactivated result with nonzero expired count");

    // a request leaving the input register always shows up as a result
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("request advanced but no result held");
`endif

endmodule

### sim/tb_global_health_supervision_fsm_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for global_health_supervision_fsm_unit
// depends on ghs_pkg and the rtl of the block; runs directed and random requests

module tb_global_health_supervision_fsm_unit;

    import ghs_pkg::*;

    localparam int          LOCAL_COUNT    = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    // codes the package leaves unnamed
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [1:0]  LANE_OK        = 2'd1;

    // running copy of the supervision state, predicts one status word per request
    class health_status_predictor;
        t_status            status;
        logic [COUNT_W-1:0] expired_count;
        bit                 timer_on;
        logic [1:0]         cause_type;
        logic [7:0]         cause_process;
        logic [1:0]         cause_cluster;
        logic [COUNT_W-1:0] tolerance;
        bit                 handler;
        t_result            awaited_status[$];
        int                 failures;

        function new();
            status        = ST_DEACT;
            expired_count = '0;
            timer_on      = 1'b1;
            cause_type    = '0;
            cause_process = '0;
            cause_cluster = '0;
            tolerance     = '0;
            handler       = 1'b0;
            failures      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TOLERANCE) begin
                tolerance = data;
            end else if (idx == CFG_HANDLER) begin
                handler = data[0];
            end
        endfunction

        function void count_up();
            if (expired_count != COUNT_MAX) begin
                expired_count++;
            end
        endfunction

        // data: lanes[15:0], rep status[17:16], type[19:18], process[27:20], cluster[29:28]
        function void note_request(logic [1:0] cmd, logic [IN_DATA_W-1:0] data);
            t_lane_flags f;
            t_result     r;
            logic [1:0]  lane;
            bit          notify;
            f = '0;
            notify = 1'b0;
            for (int i = 0; i < LOCAL_COUNT && i < LANES_MAX; i++) begin
                lane = data[LANE_W*i +: LANE_W];
                if (lane != LS_DEACT)   f.active  = 1'b1;
                if (lane == LS_FAILED)  f.failed  = 1'b1;
                if (lane == LS_EXPIRED) f.expired = 1'b1;
            end
            case (cmd)
                CMD_TICK: begin
                    if (timer_on) begin
                        if (!f.active) begin
                            status = ST_DEACT;
                            expired_count = '0;
                        end else if (status == ST_OK || status == ST_FAILED) begin
                            if (!f.expired && !f.failed) begin
                                status = ST_OK;
                            end else if (!f.expired) begin
                                status = ST_FAILED;
                            end else if (tolerance != 0) begin
                                status = ST_EXPIRED;
                                count_up();
                            end else begin
                                status = ST_STOPPED;
                            end
                        end else if (status == ST_EXPIRED && f.expired) begin
                            // a lowered tolerance below the count leaves it parked
                            if (expired_count < tolerance) begin
                                count_up();
                            end else if (expired_count == tolerance) begin
                                status = ST_STOPPED;
                            end
                        end
                        notify = (status == ST_STOPPED) && handler;
                    end
                end
                CMD_MODE: begin
                    if (!f.active) begin
                        timer_on = 1'b0;
                        status = ST_DEACT;
                        expired_count = '0;
                    end else if (status == ST_DEACT) begin
                        status = ST_OK;
                        timer_on = 1'b1;
                    end else if ((status == ST_FAILED && !f.failed) ||
                                 (status == ST_EXPIRED && !f.expired)) begin
                        status = ST_OK;
                        expired_count = '0;
                    end
                end
                CMD_REPORT: begin
                    if (data[17:16] == LS_EXPIRED) begin
                        cause_type    = data[19:18];
                        cause_process = data[27:20];
                        cause_cluster = data[29:28];
                    end
                end
                default: ;
            endcase
            r.status     = status;
            r.count      = expired_count;
            r.notify     = notify;
            r.cause_type = cause_type;
            r.process    = cause_process;
            r.cluster    = cause_cluster;
            awaited_status.insert(awaited_status.size(), r);
        endfunction

        function void compare_field(string label, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            t_result got;
            t_result want;
            got = t_result'(word);
            if (awaited_status.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                failures++;
                return;
            end
            want = awaited_status.pop_front();
            compare_field("global_status", want.status, got.status);
            compare_field("expired_cycles", want.count, got.count);
            compare_field("notify", want.notify, got.notify);
            compare_field("cause_type", want.cause_type, got.cause_type);
            compare_field("cause_process", want.process, got.process);
            compare_field("cause_cluster", want.cluster, got.cluster);
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // receiver stall pattern, walked one bit per cycle
    logic [31:0]            stall_pattern = '1;
    logic [4:0]             rx_slot       = '0;

    int                     burst_left    = 0;
    int                     idle_cycles   = 0;
    health_status_predictor status_pred   = new();

    global_health_supervision_fsm_unit #(
        .LOCAL_COUNT(LOCAL_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= stall_pattern[rx_slot];
        rx_slot <= rx_slot + 1'b1;
    end

    // handshake monitor: feeds the predictor, checks results, and guards against hangs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                status_pred.write_register(i_cfg_index, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                status_pred.note_request(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                status_pred.check_result(m_axis_tdata);
            end
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles == WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_request(logic [15:0] lanes,
                                                          logic [1:0] rep_status,
                                                          logic [1:0] rep_type,
                                                          logic [7:0] rep_process,
                                                          logic [1:0] rep_cluster);
        return {2'b00, rep_cluster, rep_process, rep_type, rep_status, lanes};
    endfunction

    // per-lane mix in percent; a few all-idle and fully random lane sets
    function automatic logic [15:0] random_lanes(int p_fail, int p_exp);
        logic [15:0] lanes;
        int          pick;
        int          r;
        pick = $urandom_range(0, 99);
        if (pick < 4) return '0;
        if (pick < 8) return 16'($urandom);
        for (int i = 0; i < LANES_MAX; i++) begin
            r = $urandom_range(0, 99);
            if (r < p_exp)                    lanes[LANE_W*i +: LANE_W] = LS_EXPIRED;
            else if (r < p_exp + p_fail)      lanes[LANE_W*i +: LANE_W] = LS_FAILED;
            else if (r < p_exp + p_fail + 10) lanes[LANE_W*i +: LANE_W] = LS_DEACT;
            else                              lanes[LANE_W*i +: LANE_W] = LANE_OK;
        end
        return lanes;
    endfunction

    function automatic logic [15:0] with_lane(logic [15:0] lanes, logic [1:0] code);
        int idx;
        idx = $urandom_range(0, LANES_MAX - 1);
        lanes[LANE_W*idx +: LANE_W] = code;
        return lanes;
    endfunction

    // sender works in bursts; valid stays high across a burst
    task automatic send_request(logic [1:0] cmd, logic [IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_lanes(logic [1:0] cmd, logic [15:0] lanes);
        send_request(cmd, pack_request(lanes, 2'($urandom), 2'($urandom), 8'($urandom),
                                       2'($urandom)));
    endtask

    task automatic send_report(logic [1:0] rep_status, logic [1:0] rep_type,
                               logic [7:0] rep_process, logic [1:0] rep_cluster);
        send_request(CMD_REPORT, pack_request(16'($urandom), rep_status, rep_type,
                                              rep_process, rep_cluster));
    endtask

    // wait for every result, then write both registers and pick a new stall pattern
    task automatic drain_and_configure(logic [7:0] tol, bit handler_on, bit steady_rx);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (status_pred.awaited_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        stall_pattern <= steady_rx ? '1 : ($urandom | 32'h0101_0101);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TOLERANCE;
        i_cfg_data  <= tol;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_HANDLER;
        i_cfg_data  <= {7'($urandom), handler_on};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_lanes(CMD_TICK, random_lanes(10, 5));
        end else if (r < 65) begin
            send_lanes(CMD_MODE, random_lanes(10, 3));
        end else if (r < 95) begin
            send_report($urandom_range(0, 1) ? LS_EXPIRED : 2'($urandom), 2'($urandom),
                        8'($urandom), 2'($urandom));
        end else begin
            send_request(CMD_UNUSED, pack_request(16'($urandom), 2'($urandom), 2'($urandom),
                                                  8'($urandom), 2'($urandom)));
        end
    endtask

    // clean start, activate, then ticks that each carry an expired lane, some reports between
    task automatic drive_expiry_run(int ticks);
        send_lanes(CMD_TICK, 16'h0000);
        send_lanes(CMD_MODE, (16'($urandom) & 16'h5555) | 16'h0001);
        repeat (ticks) begin
            if ($urandom_range(0, 5) == 0) begin
                send_report(2'($urandom), 2'($urandom), 8'($urandom), 2'($urandom));
            end
            send_lanes(CMD_TICK, with_lane(random_lanes(10, 20), LS_EXPIRED));
        end
    endtask

    // mostly well-formed runs (expiry toward the tolerance, failure then recovery), some noise
    task automatic run_random_phase(int n);
        int sent;
        int kind;
        int len;
        int len_max;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            len_max = status_pred.tolerance + 3;
            if (len_max > 12) len_max = 12;
            len = (kind <= 3) ? $urandom_range(1, len_max) : $urandom_range(1, 6);
            repeat (len) begin
                if (kind <= 3) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_report(LS_EXPIRED, 2'($urandom), 8'($urandom), 2'($urandom));
                    end else begin
                        send_lanes(CMD_TICK, with_lane(random_lanes(10, 15), LS_EXPIRED));
                    end
                end else if (kind <= 5) begin
                    send_lanes(CMD_TICK, with_lane(random_lanes(20, 0), LS_FAILED));
                end else begin
                    send_noise();
                end
                sent++;
            end
            if (kind <= 5 && $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 2))
                    0:       send_lanes(CMD_MODE, random_lanes(10, 0));
                    1:       send_lanes(CMD_TICK, 16'h0000);
                    default: send_lanes(CMD_MODE, 16'h0000);
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk through every state and transition, tolerance 2 with handler
        drain_and_configure(8'd2, 1'b1, 1'b1);
        send_lanes(CMD_TICK, 16'h0000);              // all idle, stays deactivated
        send_lanes(CMD_TICK, 16'h5555);              // deactivated ignores active lanes
        send_report(LS_EXPIRED, 2'd3, 8'hFF, 2'd3);  // out-of-range type is latched
        send_report(LS_FAILED, 2'd1, 8'h00, 2'd0);   // not expired, no latch
        send_request(CMD_UNUSED, pack_request(16'hFFFF, 2'd3, 2'd3, 8'hFF, 2'd3));
        send_lanes(CMD_MODE, 16'h4000);              // activate from top lane
        send_lanes(CMD_TICK, 16'h5555);
        send_lanes(CMD_TICK, 16'h9555);              // top lane failed
        send_lanes(CMD_MODE, 16'h9555);              // still failed, no recovery
        send_lanes(CMD_MODE, 16'h5555);              // recover to ok
        send_lanes(CMD_TICK, 16'h0003);              // first expired cycle
        send_lanes(CMD_TICK, 16'hFFFF);
        send_lanes(CMD_TICK, 16'h0003);              // tolerance reached, stopped
        send_lanes(CMD_TICK, 16'h5555);              // stopped holds and notifies again
        send_lanes(CMD_MODE, 16'h5555);              // mode switch leaves stopped alone
        send_lanes(CMD_TICK, 16'h0000);              // all idle clears even stopped
        send_lanes(CMD_MODE, 16'h0001);
        send_lanes(CMD_TICK, 16'hC000);
        send_lanes(CMD_MODE, 16'hC001);              // expired lane blocks recovery
        send_lanes(CMD_TICK, 16'h0009);              // expired without expired lane holds
        send_lanes(CMD_MODE, 16'h0005);              // recover from expired
        send_lanes(CMD_MODE, 16'h0000);              // deactivate, timer stops
        send_lanes(CMD_TICK, 16'hFFFF);              // ignored with timer stopped
        send_lanes(CMD_MODE, 16'hAAAA);              // restart timer
        send_report(LS_EXPIRED, 2'd0, 8'h00, 2'd0);

        // zero tolerance goes straight to stopped, no handler means no notify
        drain_and_configure(8'd0, 1'b0, 1'b0);
        send_lanes(CMD_TICK, 16'hAAAA);
        send_lanes(CMD_TICK, 16'hC000);
        send_lanes(CMD_TICK, 16'h0000);
        run_random_phase(60);

        // widest tolerance: count climbs to its ceiling, then stops
        drain_and_configure(8'd255, 1'b1, 1'b0);
        drive_expiry_run(257);

        drain_and_configure(8'd1, 1'b1, 1'b1);
        run_random_phase(90);

        // park the count at 5, then lower the tolerance beneath it
        drain_and_configure(8'd5, 1'b0, 1'b0);
        run_random_phase(40);
        drive_expiry_run(5);
        drain_and_configure(8'd2, 1'b1, 1'b0);
        send_lanes(CMD_TICK, with_lane(16'h5555, LS_EXPIRED));
        send_lanes(CMD_TICK, 16'h5555);
        run_random_phase(60);

        drain_and_configure(8'($urandom_range(3, 8)), 1'($urandom), 1'b0);
        run_random_phase(100);

        s_axis_tvalid <= 1'b0;
        while (status_pred.awaited_status.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (status_pred.failures == 0 && status_pred.awaited_status.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ghs_pkg.sv
hw/rtl/ghs_lane_reduce.sv
hw/rtl/ghs_fsm_core.sv
hw/rtl/global_health_supervision_fsm_unit.sv
sim/tb_global_health_supervision_fsm_unit.sv
